@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFD_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MFD_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ rtl/mfd_pkg.sv @@
// Shared types and constants of the motion frame deframer.
package mfd_pkg;

	localparam int ByteW   = 8;
	localparam int PosW    = 3;
	localparam int CfgIdxW = 2;

	typedef logic [ByteW-1:0]   byte_t;
	typedef logic [PosW-1:0]    pos_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam byte_t HdrFirst  = 8'hAA;
	localparam byte_t HdrSecond = 8'h55;
	localparam byte_t TailByte  = 8'hFF;

	localparam byte_t SenderRst = 8'h01;
	localparam byte_t KindRst   = 8'h10;

	localparam cfg_idx_t RegSender = 2'd0;
	localparam cfg_idx_t RegKind   = 2'd1;

	typedef struct packed {
		logic  frame_valid;
		byte_t motion_code;
	} result_t;

	typedef struct packed {
		byte_t expected_sender;
		byte_t expected_kind;
	} cfg_t;

	typedef struct packed {
		logic in_frame;
		pos_t byte_position;
	} status_t;

endpackage

@@ rtl/mfd_byte_if.sv @@
// Input byte channel.
interface mfd_byte_if;
	logic          valid;
	logic          ready;
	mfd_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/mfd_result_if.sv @@
// Result channel: frame verdict and motion code.
interface mfd_result_if;
	logic           valid;
	logic           ready;
	logic           frame_valid;
	mfd_pkg::byte_t motion_code;

	modport source (output valid, output frame_valid, output motion_code, input ready);
	modport sink   (input valid, input frame_valid, input motion_code, output ready);
endinterface

@@ rtl/mfd_cfg_if.sv @@
// Configuration write channel.
interface mfd_cfg_if;
	logic              valid;
	logic              ready;
	mfd_pkg::cfg_idx_t index;
	mfd_pkg::byte_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mfd_cfg_regs.sv @@
// Configuration registers: expected sender and data type.
module mfd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	mfd_cfg_if.sink       cfg,
	output mfd_pkg::cfg_t cfg_val
);

	mfd_pkg::byte_t sender_q;
	mfd_pkg::byte_t kind_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_q <= mfd_pkg::SenderRst;
			kind_q   <= mfd_pkg::KindRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				mfd_pkg::RegSender: sender_q <= cfg.data;
				mfd_pkg::RegKind:   kind_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_val.expected_sender = sender_q;
	assign cfg_val.expected_kind   = kind_q;

endmodule

@@ rtl/mfd_parser.sv @@
// Frame hunter and checker: one received byte per cycle, advancing only on accepted bytes.
module mfd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  mfd_pkg::byte_t   rx_byte,
	input  mfd_pkg::cfg_t    cfg_val,
	output logic             emit,
	output mfd_pkg::result_t result,
	output mfd_pkg::status_t status
);

	localparam mfd_pkg::pos_t PosHdr1   = 3'd0;
	localparam mfd_pkg::pos_t PosHdr2   = 3'd1;
	localparam mfd_pkg::pos_t PosSender = 3'd2;
	localparam mfd_pkg::pos_t PosKind   = 3'd3;
	localparam mfd_pkg::pos_t PosCode   = 3'd4;
	localparam mfd_pkg::pos_t PosSum    = 3'd5;

	mfd_pkg::pos_t  pos_q, pos_d;
	logic           in_frame_q, in_frame_d;
	mfd_pkg::byte_t sum_q, sum_d;
	logic           fmatch_q, fmatch_d;
	mfd_pkg::byte_t payload_q, payload_d;
	logic           smatch_q, smatch_d;
	mfd_pkg::byte_t sum_add;

	assign sum_add = mfd_pkg::byte_t'(sum_q + rx_byte);

	// next byte completes the frame when in the body and past the checksum
	assign emit = in_frame_q && !(pos_q == PosSender || pos_q == PosKind ||
		pos_q == PosCode || pos_q == PosSum);

	always_comb begin
		pos_d      = pos_q;
		in_frame_d = in_frame_q;
		sum_d      = sum_q;
		fmatch_d   = fmatch_q;
		payload_d  = payload_q;
		smatch_d   = smatch_q;
		if (!in_frame_q) begin
			if (pos_q == PosHdr1 && rx_byte == mfd_pkg::HdrFirst) begin
				sum_d    = rx_byte;
				fmatch_d = 1'b1;
				smatch_d = 1'b0;
				pos_d    = PosHdr2;
			end else if (pos_q == PosHdr2 && rx_byte == mfd_pkg::HdrSecond) begin
				sum_d      = sum_add;
				pos_d      = PosSender;
				in_frame_d = 1'b1;
			end else begin
				pos_d = PosHdr1;
			end
		end else begin
			case (pos_q)
				PosSender: begin
					if (rx_byte != cfg_val.expected_sender) fmatch_d = 1'b0;
					sum_d = sum_add;
					pos_d = PosKind;
				end
				PosKind: begin
					if (rx_byte != cfg_val.expected_kind) fmatch_d = 1'b0;
					sum_d = sum_add;
					pos_d = PosCode;
				end
				PosCode: begin
					payload_d = rx_byte;
					sum_d     = sum_add;
					pos_d     = PosSum;
				end
				PosSum: begin
					smatch_d = (rx_byte == sum_q);
					pos_d    = mfd_pkg::pos_t'(PosSum + 3'd1);
				end
				default: begin
					pos_d      = PosHdr1;
					in_frame_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= PosHdr1;
			in_frame_q <= 1'b0;
			sum_q      <= '0;
			fmatch_q   <= 1'b1;
			payload_q  <= '0;
			smatch_q   <= 1'b0;
		end else if (accept) begin
			pos_q      <= pos_d;
			in_frame_q <= in_frame_d;
			sum_q      <= sum_d;
			fmatch_q   <= fmatch_d;
			payload_q  <= payload_d;
			smatch_q   <= smatch_d;
		end
	end

	assign result.frame_valid = fmatch_q && smatch_q && (rx_byte == mfd_pkg::TailByte);
	assign result.motion_code = payload_q;

	assign status.in_frame      = in_frame_q;
	assign status.byte_position = pos_q;

endmodule

@@ rtl/mfd_out_reg.sv @@
// Result register in front of the output channel.
module mfd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mfd_pkg::result_t result,
	output logic             free,
	mfd_result_if.source     res
);

	logic             valid_q;
	mfd_pkg::result_t data_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign res.valid       = valid_q;
	assign res.frame_valid = data_q.frame_valid;
	assign res.motion_code = data_q.motion_code;

endmodule

@@ rtl/motion_frame_deframer.sv @@
// Motion frame deframer top level.
// A frame's result is registered and appears in the cycle after its seventh byte is accepted.
// Throughput: one byte per cycle; the frame state advances once per accepted byte.
// A tail byte is held off only while a previous result is stalled at the output.
// Reset (arst_n low, async): hunting for the header, no result pending,
// expected sender 0x01 and expected type 0x10.
`include "assert_macros.svh"

module motion_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	mfd_byte_if.sink    rx,
	mfd_result_if.source res,
	mfd_cfg_if.sink     cfg
);

	mfd_pkg::cfg_t    cfg_val;
	mfd_pkg::result_t result;
	mfd_pkg::status_t status;
	logic             emit;
	logic             free;
	logic             accept;

	assign rx.ready = !emit || free;
	assign accept   = rx.valid && rx.ready;

	mfd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	mfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.cfg_val (cfg_val),
		.emit    (emit),
		.result  (result),
		.status  (status)
	);

	mfd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && emit),
		.result (result),
		.free   (free),
		.res    (res)
	);

	`MFD_ASSERT_NOW(a_no_overwrite, clk, arst_n, accept && emit, free)
	`MFD_ASSERT_NEXT(a_tail_rehunts, clk, arst_n, accept && emit,
		!status.in_frame && status.byte_position == '0)
	`MFD_ASSERT_NOW(a_res_from_tail, clk, arst_n, $rose(res.valid), $past(accept && emit))
	`MFD_ASSERT_NOW(a_body_pos, clk, arst_n, status.in_frame,
		status.byte_position >= 3'd2 && status.byte_position <= 3'd6)

endmodule

@@ tb/mfd_frame_checker.sv @@
// Frame checker: predicts each frame verdict from the byte stream and compares results.
`timescale 1ns / 1ps

module mfd_frame_checker (
	input  logic  clk,
	input  logic  arst_n,
	mfd_byte_if   rx,
	mfd_result_if res,
	mfd_cfg_if    cfg,
	output int    fails,
	output int    pending,
	output int    frames_seen,
	output int    good_frames
);
	import mfd_pkg::*;

	localparam pos_t PosIdle   = 3'd0;
	localparam pos_t PosSync   = 3'd1;
	localparam pos_t PosSender = 3'd2;
	localparam pos_t PosKind   = 3'd3;
	localparam pos_t PosCode   = 3'd4;
	localparam pos_t PosSum    = 3'd5;
	localparam pos_t PosTail   = 3'd6;

	cfg_t    regs;
	pos_t    pos;
	logic    collecting;
	logic    ids_ok;
	logic    sum_ok;
	byte_t   csum;
	byte_t   code;
	result_t due_results[$];
	result_t want;
	result_t got;
	logic    produced;

	// One step of the deframer: returns 1 when this byte closes a frame.
	function automatic logic advance_frame(input byte_t b, output result_t r);
		r = '0;
		if (!collecting) begin
			if (pos == PosIdle && b == HdrFirst) begin
				csum   = b;
				ids_ok = 1'b1;
				sum_ok = 1'b0;
				pos    = PosSync;
			end else if (pos == PosSync && b == HdrSecond) begin
				csum       = csum + b;
				pos        = PosSender;
				collecting = 1'b1;
			end else begin
				pos = PosIdle;
			end
			return 1'b0;
		end
		case (pos)
			PosSender: begin
				if (b != regs.expected_sender)
					ids_ok = 1'b0;
				csum = csum + b;
				pos  = PosKind;
			end
			PosKind: begin
				if (b != regs.expected_kind)
					ids_ok = 1'b0;
				csum = csum + b;
				pos  = PosCode;
			end
			PosCode: begin
				code = b;
				csum = csum + b;
				pos  = PosSum;
			end
			PosSum: begin
				sum_ok = (b == csum);
				pos    = PosTail;
			end
			default: begin
				r.frame_valid = ids_ok && sum_ok && (b == TailByte);
				r.motion_code = code;
				pos           = PosIdle;
				collecting    = 1'b0;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.expected_sender = SenderRst;
			regs.expected_kind   = KindRst;
			pos         = PosIdle;
			collecting  = 1'b0;
			ids_ok      = 1'b1;
			sum_ok      = 1'b0;
			csum        = '0;
			code        = '0;
			due_results.delete();
			fails       = 0;
			pending     = 0;
			frames_seen = 0;
			good_frames = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == RegSender)
					regs.expected_sender = cfg.data;
				else if (cfg.index == RegKind)
					regs.expected_kind = cfg.data;
			end
			if (rx.valid && rx.ready) begin
				produced = advance_frame(rx.rx_byte, want);
				if (produced)
					due_results.push_back(want);
			end
			if (res.valid && res.ready) begin
				got.frame_valid = res.frame_valid;
				got.motion_code = res.motion_code;
				frames_seen++;
				if (due_results.size() == 0) begin
					fails++;
					$error("unexpected result: frame_valid %0d, motion_code 0x%02h",
						got.frame_valid, got.motion_code);
				end else begin
					want = due_results.pop_front();
					if (want.frame_valid)
						good_frames++;
					if (got.frame_valid !== want.frame_valid) begin
						fails++;
						$error("frame_valid: expected %0d, got %0d",
							want.frame_valid, got.frame_valid);
					end
					if (got.motion_code !== want.motion_code) begin
						fails++;
						$error("motion_code: expected 0x%02h, got 0x%02h",
							want.motion_code, got.motion_code);
					end
				end
			end
			pending = due_results.size();
		end
	end

endmodule

@@ tb/motion_frame_deframer_test.sv @@
// Testbench top: clock, reset, byte and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module motion_frame_deframer_test;
	import mfd_pkg::*;

	localparam cfg_idx_t RegSpareA  = 2'd2;
	localparam cfg_idx_t RegSpareB  = 2'd3;
	localparam int       StallLimit = 2000;
	localparam int       Phases     = 6;
	localparam int       PhaseBytes = 250;

	typedef enum int {FlawNone, FlawSender, FlawKind, FlawSum, FlawTail, FlawWild} flaw_t;

	logic clk;
	logic arst_n;
	logic steady;
	int   fails;
	int   pending;
	int   frames_seen;
	int   good_frames;
	int   bytes_sent;
	int   reg_writes;
	int   idle_cycles;
	byte_t sender_now;
	byte_t kind_now;

	mfd_byte_if   rx_ch ();
	mfd_result_if res_ch ();
	mfd_cfg_if    cfg_ch ();

	motion_frame_deframer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	mfd_frame_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx_ch),
		.res         (res_ch),
		.cfg         (cfg_ch),
		.fails       (fails),
		.pending     (pending),
		.frames_seen (frames_seen),
		.good_frames (good_frames)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic byte_t flip_mask();
		return byte_t'($urandom_range(1, 255));
	endfunction

	task automatic put_byte(input byte_t b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			rx_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   = 1'b1;
		rx_ch.rx_byte = b;
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
		rx_ch.valid = 1'b0;
		bytes_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input byte_t d);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = d;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		if (idx == RegSender)
			sender_now = d;
		else if (idx == RegKind)
			kind_now = d;
		reg_writes++;
	endtask

	// Hold the byte stream until every predicted result has come out.
	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_frame(input byte_t code, input flaw_t flaw);
		byte_t s;
		byte_t k;
		byte_t cs;
		byte_t tl;
		s  = sender_now;
		k  = kind_now;
		tl = TailByte;
		case (flaw)
			FlawSender: s = s ^ flip_mask();
			FlawKind:   k = k ^ flip_mask();
			FlawTail:   tl = tl ^ flip_mask();
			FlawWild: begin
				s = byte_t'($urandom());
				k = byte_t'($urandom());
			end
			default: ;
		endcase
		cs = HdrFirst + HdrSecond + s + k + code;
		if (flaw == FlawSum)
			cs = cs ^ flip_mask();
		put_byte(HdrFirst);
		put_byte(HdrSecond);
		put_byte(s);
		put_byte(k);
		put_byte(code);
		put_byte(cs);
		put_byte(tl);
	endtask

	task automatic put_noise();
		int n;
		int pick;
		n = $urandom_range(1, 4);
		repeat (n) begin
			pick = $urandom_range(0, 3);
			if (pick == 0)
				put_byte(HdrFirst);
			else if (pick == 1)
				put_byte(HdrSecond);
			else
				put_byte(byte_t'($urandom()));
		end
	endtask

	task automatic put_broken_header();
		byte_t b;
		if ($urandom_range(0, 1)) begin
			put_byte(HdrFirst);
			put_byte(HdrFirst);
			put_byte(HdrSecond);
		end else begin
			b = byte_t'($urandom());
			if (b == HdrSecond)
				b = ~b;
			put_byte(HdrFirst);
			put_byte(b);
		end
	endtask

	// Result side stalls per item, except during steady phases.
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			res_ch.ready = 1'b0;
			repeat (stall) @(negedge clk);
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int    phase;
		int    start;
		int    pick;
		byte_t cs;
		arst_n        = 1'b0;
		steady        = 1'b0;
		bytes_sent    = 0;
		reg_writes    = 0;
		sender_now    = SenderRst;
		kind_now      = KindRst;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = RegSender;
		cfg_ch.data   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// unused register indexes must leave the checks untouched
		write_reg(RegSpareA, 8'h00);
		write_reg(RegSpareB, 8'hFF);
		put_frame(8'h00, FlawNone);
		put_byte(HdrFirst);
		put_byte(HdrFirst);
		put_byte(HdrSecond);
		put_frame(8'hFF, FlawTail);

		// type register changed between the sender and type bytes
		put_byte(HdrFirst);
		put_byte(HdrSecond);
		put_byte(sender_now);
		settle();
		write_reg(RegKind, 8'h20);
		cs = HdrFirst + HdrSecond + sender_now + kind_now + 8'h5A;
		put_byte(kind_now);
		put_byte(8'h5A);
		put_byte(cs);
		put_byte(TailByte);
		settle();

		for (phase = 0; phase < Phases; phase++) begin
			case (phase)
				0: begin
					write_reg(RegSender, SenderRst);
					write_reg(RegKind, KindRst);
				end
				1: begin
					write_reg(RegSender, 8'h00);
					write_reg(RegKind, 8'hFF);
				end
				2: begin
					write_reg(RegSender, 8'hFF);
					write_reg(RegKind, 8'h00);
				end
				default: begin
					write_reg(RegSender, byte_t'($urandom()));
					write_reg(RegKind, byte_t'($urandom()));
				end
			endcase
			steady = (phase == 2);
			start  = bytes_sent;
			while (bytes_sent - start < PhaseBytes) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					pick = $urandom_range(0, 9);
					case (pick)
						5:       put_frame(byte_t'($urandom()), FlawSender);
						6:       put_frame(byte_t'($urandom()), FlawKind);
						7:       put_frame(byte_t'($urandom()), FlawSum);
						8:       put_frame(byte_t'($urandom()), FlawTail);
						9:       put_frame(byte_t'($urandom()), FlawWild);
						default: put_frame(byte_t'($urandom()), FlawNone);
					endcase
				end else if (pick < 85) begin
					put_noise();
				end else begin
					put_broken_header();
				end
				if (phase == 3 && bytes_sent - start >= PhaseBytes / 2 &&
						bytes_sent - start < PhaseBytes / 2 + 7)
					settle();
			end
			steady = 1'b0;
			settle();
		end

		$display("Sent %0d bytes with %0d register writes over %0d settings.",
			bytes_sent, reg_writes, Phases + 2);
		$display("Checked %0d frame results, %0d of them accepted as valid.",
			frames_seen, good_frames);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
